// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CSOT_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
	else $error(msg);

// Concurrent assertion on the block clock and reset.
`define CSOT_ASSERT(label, prop, msg) `CSOT_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ----- rtl/csot_pkg.sv -----
package csot_pkg;

	// Default values of the top-level parameters.
	localparam int DEF_NUM_CHANNELS = 8;
	localparam int DEF_FRAC_BITS    = 8;

	// Field widths.
	localparam int CMD_W      = 2;
	localparam int ERR_W      = 18;
	localparam int RSSI_W     = 9;
	localparam int RSSI_MAG_W = 8;
	localparam int CNT_W      = 16;
	localparam int CH_OUT_W   = 3;
	localparam int DWELL_W    = 16;
	localparam int WEIGHT_W   = 9;
	localparam int THR_W      = 17;
	localparam int CFG_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int WEIGHT_SHIFT = 8;

	// Stream data widths, rounded up to whole bytes.
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;

	// Register reset values and limits.
	localparam logic [DWELL_W-1:0]  DWELL_RESET  = 16'd5000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd77;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
	localparam logic [THR_W-1:0]    WARN_RESET   = 17'd5000;
	localparam logic [THR_W-1:0]    ALARM_RESET  = 17'd15000;
	localparam logic [CNT_W-1:0]    CNT_MAX      = '1;
	localparam logic [DWELL_W-1:0]  DWELL_MAX    = '1;

	// Input item kinds.
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_PACKET = 2'd1,
		CMD_CLEAR  = 2'd2
	} csot_cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DWELL_TICKS = 2'd0,
		REG_EMA_WEIGHT  = 2'd1,
		REG_WARN_THR    = 2'd2,
		REG_ALARM_THR   = 2'd3
	} csot_reg_t;

	// Offset severity classes.
	typedef enum logic [1:0] {
		CLASS_OK    = 2'd0,
		CLASS_WARN  = 2'd1,
		CLASS_ALARM = 2'd2
	} csot_class_t;

	// One result item; the last member lands in the lowest bits.
	typedef struct packed {
		csot_class_t               offset_class;
		logic                      has_data;
		logic [CNT_W-1:0]          packet_count;
		logic signed [RSSI_W-1:0]  last_rssi_dbm;
		logic signed [ERR_W-1:0]   avg_offset_hz;
		logic [CH_OUT_W-1:0]       rec_channel;
		logic                      retune;
		logic [CH_OUT_W-1:0]       channel;
	} csot_result_t;

	localparam int RES_W = $bits(csot_result_t);

endpackage

// ----- rtl/csot_update.sv -----
module csot_update #(
	parameter int NUM_CHANNELS = csot_pkg::DEF_NUM_CHANNELS,
	parameter int FRAC_BITS    = csot_pkg::DEF_FRAC_BITS,
	parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
	parameter int OFS_W        = csot_pkg::ERR_W + FRAC_BITS
) (
	input  logic [csot_pkg::CMD_W-1:0]         cmd,
	input  logic signed [csot_pkg::ERR_W-1:0]  freq_err_hz,
	input  logic signed [csot_pkg::RSSI_W-1:0] rssi_dbm,
	input  logic [CH_W-1:0]                    cur_ch,
	input  logic [csot_pkg::DWELL_W-1:0]       dwell_cnt,
	input  logic [csot_pkg::DWELL_W-1:0]       dwell_ticks,
	input  logic [csot_pkg::WEIGHT_W-1:0]      ema_weight,
	input  logic [csot_pkg::THR_W-1:0]         warn_thr,
	input  logic [csot_pkg::THR_W-1:0]         alarm_thr,
	input  logic signed [OFS_W-1:0]            rec_ofs,
	input  logic [csot_pkg::RSSI_MAG_W-1:0]    rec_rssi,
	input  logic [csot_pkg::CNT_W-1:0]         rec_cnt,
	input  logic                               rec_valid,
	output csot_pkg::csot_result_t             result,
	output logic [CH_W-1:0]                    nxt_ch,
	output logic [csot_pkg::DWELL_W-1:0]       nxt_dwell,
	output logic                               rec_write,
	output logic                               clear_all,
	output logic signed [OFS_W-1:0]            new_ofs,
	output logic [csot_pkg::RSSI_MAG_W-1:0]    new_rssi,
	output logic [csot_pkg::CNT_W-1:0]         new_cnt
);
	import csot_pkg::*;

	localparam int PROD_W = OFS_W + 1 + WEIGHT_W + 1;

	csot_cmd_t                 cmd_e;
	logic [DWELL_W-1:0]        dwell_lim;
	logic [DWELL_W-1:0]        dwell_inc;
	logic                      hop;
	logic [CH_W-1:0]           ch_plus;
	logic signed [OFS_W-1:0]   eq;
	logic signed [OFS_W:0]     diff;
	logic [WEIGHT_W-1:0]       w_sat;
	logic signed [WEIGHT_W:0]  w_s;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  old_ext;
	logic signed [PROD_W-1:0]  acc;
	logic signed [OFS_W-1:0]   q;
	logic [RSSI_MAG_W-1:0]     r;
	logic [CNT_W-1:0]          cnt;
	logic                      vld;
	logic                      retune;
	logic [OFS_W-1:0]          q_mag;
	logic [OFS_W-1:0]          warn_fx;
	logic [OFS_W-1:0]          alarm_fx;

	assign cmd_e = csot_cmd_t'(cmd);

	// Dwell counting: a zero limit behaves as one, the count saturates.
	assign dwell_lim = (dwell_ticks == '0) ? DWELL_W'(1) : dwell_ticks;
	assign dwell_inc = (dwell_cnt == DWELL_MAX) ? dwell_cnt : dwell_cnt + DWELL_W'(1);
	assign hop       = (dwell_inc >= dwell_lim);
	assign ch_plus   = (cur_ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : cur_ch + CH_W'(1);

	// Moving average as old + w*(new - old), floored by the arithmetic shift.
	assign eq      = {freq_err_hz, {FRAC_BITS{1'b0}}};
	assign diff    = {eq[OFS_W-1], eq} - {rec_ofs[OFS_W-1], rec_ofs};
	assign w_sat   = (ema_weight > WEIGHT_ONE) ? WEIGHT_ONE : ema_weight;
	assign w_s     = {1'b0, w_sat};
	assign prod    = diff * w_s;
	assign old_ext = PROD_W'(rec_ofs);
	assign acc     = (old_ext <<< WEIGHT_SHIFT) + prod;

	// Packet record contents.
	assign new_ofs  = rec_valid ? acc[OFS_W+WEIGHT_SHIFT-1:WEIGHT_SHIFT] : eq;
	assign new_cnt  = (rec_cnt == CNT_MAX) ? rec_cnt : rec_cnt + CNT_W'(1);
	always_comb begin
		priority if (!rssi_dbm[RSSI_W-1]) begin
			new_rssi = '0;
		end else if (rssi_dbm[RSSI_W-2:0] == '0) begin
			// The most negative input saturates to the largest magnitude.
			new_rssi = '1;
		end else begin
			new_rssi = RSSI_MAG_W'(-rssi_dbm);
		end
	end

	// Next state and the record to report.
	always_comb begin
		nxt_ch         = cur_ch;
		nxt_dwell      = dwell_cnt;
		rec_write      = 1'b0;
		clear_all      = 1'b0;
		retune         = 1'b0;
		q              = rec_ofs;
		r              = rec_rssi;
		cnt            = rec_cnt;
		vld            = rec_valid;
		unique case (cmd_e)
			CMD_TICK: begin
				nxt_dwell = hop ? '0 : dwell_inc;
				if (hop) begin
					nxt_ch = ch_plus;
					retune = 1'b1;
				end
			end
			CMD_PACKET: begin
				rec_write = 1'b1;
				q         = new_ofs;
				r         = new_rssi;
				cnt       = new_cnt;
				vld       = 1'b1;
			end
			CMD_CLEAR: begin
				clear_all = 1'b1;
				nxt_ch    = '0;
				nxt_dwell = '0;
				retune    = 1'b1;
				cnt       = '0;
				vld       = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Severity compares the exact fixed-point magnitude.
	assign q_mag    = q[OFS_W-1] ? (~q + OFS_W'(1)) : q;
	assign warn_fx  = {1'b0, warn_thr, {FRAC_BITS{1'b0}}};
	assign alarm_fx = {1'b0, alarm_thr, {FRAC_BITS{1'b0}}};

	// Result fields; a record without data reports zero payload.
	always_comb begin
		result.channel      = CH_OUT_W'(nxt_ch);
		result.retune       = retune;
		result.rec_channel  = CH_OUT_W'(cur_ch);
		result.packet_count = cnt;
		result.has_data     = vld;
		result.avg_offset_hz = '0;
		result.last_rssi_dbm = '0;
		result.offset_class  = CLASS_OK;
		if (vld) begin
			result.avg_offset_hz = q[OFS_W-1:FRAC_BITS];
			result.last_rssi_dbm = RSSI_W'(0) - {1'b0, r};
			priority if (q_mag > alarm_fx) begin
				result.offset_class = CLASS_ALARM;
			end else if (q_mag > warn_fx) begin
				result.offset_class = CLASS_WARN;
			end else begin
				result.offset_class = CLASS_OK;
			end
		end
	end

endmodule

// ----- rtl/channel_scan_offset_tracker_unit.sv -----
// Channel      | Direction | tdata                                | tuser
// s_axis       | in        | freq_err_hz, rssi_dbm                | cmd
// m_axis       | out       | channel ... offset_class (53 bits)   | -
// cfg          | in        | write enable, index, data            | -
//
// Each transaction passes an input register and a result register; one item is
// accepted per cycle while the result register is not stalled.
// The record read-modify-write and the channel hop happen as the item moves
// into the result register, so consecutive items see each other's updates.
// Reset clears the counts, valid flags, channel and dwell count, and loads the configuration registers.
// A stalled result holds the input register, which then stalls the input.
module channel_scan_offset_tracker_unit #(
	parameter int NUM_CHANNELS = csot_pkg::DEF_NUM_CHANNELS,
	parameter int FRAC_BITS    = csot_pkg::DEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [17:0] freq_err_hz, [26:18] rssi_dbm, [31:27] zero
	input  logic [csot_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] cmd
	input  logic [csot_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [2:0] channel, [3] retune, [6:4] rec_channel, [24:7] avg_offset_hz,
	// [33:25] last_rssi_dbm, [49:34] packet_count, [50] has_data,
	// [52:51] offset_class, [55:53] zero
	output logic [csot_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [csot_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csot_pkg::CFG_W-1:0]         cfg_wdata
);
	import csot_pkg::*;

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int OFS_W = ERR_W + FRAC_BITS;

	// Configuration registers.
	logic [DWELL_W-1:0]  dwell_ticks_q;
	logic [WEIGHT_W-1:0] ema_weight_q;
	logic [THR_W-1:0]    warn_thr_q;
	logic [THR_W-1:0]    alarm_thr_q;

	// Channel records and scan state.
	logic signed [OFS_W-1:0] ofs_q   [NUM_CHANNELS];
	logic [RSSI_MAG_W-1:0]   rssi_q  [NUM_CHANNELS];
	logic [CNT_W-1:0]        cnt_q   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] valid_q;
	logic [CH_W-1:0]         cur_ch_q;
	logic [DWELL_W-1:0]      dwell_q;

	// Input register.
	logic                      valid_s1;
	logic [CMD_W-1:0]          cmd_s1;
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [RSSI_W-1:0]  rssi_s1;

	// Result register.
	logic                      valid_s2;
	csot_result_t              result_s2;

	csot_result_t              result;
	logic [CH_W-1:0]           nxt_ch;
	logic [DWELL_W-1:0]        nxt_dwell;
	logic                      rec_write;
	logic                      clear_all;
	logic signed [OFS_W-1:0]   new_ofs;
	logic [RSSI_MAG_W-1:0]     new_rssi;
	logic [CNT_W-1:0]          new_cnt;
	logic                      advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = M_TDATA_W'(result_s2);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= DWELL_RESET;
			ema_weight_q  <= WEIGHT_RESET;
			warn_thr_q    <= WARN_RESET;
			alarm_thr_q   <= ALARM_RESET;
		end else if (cfg_we) begin
			unique case (csot_reg_t'(cfg_index))
				REG_DWELL_TICKS: dwell_ticks_q <= cfg_wdata[DWELL_W-1:0];
				REG_EMA_WEIGHT:  ema_weight_q  <= cfg_wdata[WEIGHT_W-1:0];
				REG_WARN_THR:    warn_thr_q    <= cfg_wdata[THR_W-1:0];
				REG_ALARM_THR:   alarm_thr_q   <= cfg_wdata[THR_W-1:0];
			endcase
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			err_s1  <= s_axis_tdata[ERR_W-1:0];
			rssi_s1 <= s_axis_tdata[ERR_W+RSSI_W-1:ERR_W];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	// Record update and result for the item in the input register.
	csot_update #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.FRAC_BITS    (FRAC_BITS),
		.CH_W         (CH_W),
		.OFS_W        (OFS_W)
	) u_update (
		.cmd          (cmd_s1),
		.freq_err_hz  (err_s1),
		.rssi_dbm     (rssi_s1),
		.cur_ch       (cur_ch_q),
		.dwell_cnt    (dwell_q),
		.dwell_ticks  (dwell_ticks_q),
		.ema_weight   (ema_weight_q),
		.warn_thr     (warn_thr_q),
		.alarm_thr    (alarm_thr_q),
		.rec_ofs      (ofs_q[cur_ch_q]),
		.rec_rssi     (rssi_q[cur_ch_q]),
		.rec_cnt      (cnt_q[cur_ch_q]),
		.rec_valid    (valid_q[cur_ch_q]),
		.result       (result),
		.nxt_ch       (nxt_ch),
		.nxt_dwell    (nxt_dwell),
		.rec_write    (rec_write),
		.clear_all    (clear_all),
		.new_ofs      (new_ofs),
		.new_rssi     (new_rssi),
		.new_cnt      (new_cnt)
	);

	// Scan state, packet counts and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ch_q <= '0;
			dwell_q  <= '0;
			valid_q  <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (advance) begin
			cur_ch_q <= nxt_ch;
			dwell_q  <= nxt_dwell;
			if (clear_all) begin
				valid_q <= '0;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					cnt_q[i] <= '0;
				end
			end else if (rec_write) begin
				valid_q[cur_ch_q] <= 1'b1;
				cnt_q[cur_ch_q]   <= new_cnt;
			end
		end
	end

	// Offset and RSSI entries are meaningful only once their valid flag is set.
	always_ff @(posedge clk) begin
		if (advance && rec_write) begin
			ofs_q[cur_ch_q]  <= new_ofs;
			rssi_q[cur_ch_q] <= new_rssi;
		end
	end

endmodule

// ----- rtl/csot_checker.sv -----
`include "assert_macros.svh"

module csot_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [csot_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import csot_pkg::*;

	csot_result_t res;

	assign res = csot_result_t'(m_axis_tdata[RES_W-1:0]);

	// A result waiting on the sink keeps its contents.
	`CSOT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// A record without data never exposes stored offset or RSSI.
	`CSOT_ASSERT(a_empty_record, m_axis_tvalid && !res.has_data |-> res.avg_offset_hz == '0 && res.last_rssi_dbm == '0 && res.offset_class == CLASS_OK, "empty record reported payload")

	// A record with data has a nonzero saturating packet count.
	`CSOT_ASSERT(a_count_nonzero, m_axis_tvalid && res.has_data |-> res.packet_count != '0, "valid record with zero count")

	// Without a retune the channel stays where the record came from.
	`CSOT_ASSERT(a_no_hop, m_axis_tvalid && !res.retune |-> res.channel == res.rec_channel, "channel moved without retune")

endmodule

bind channel_scan_offset_tracker_unit csot_checker u_csot_checker (.*);

// ----- tb/channel_scan_offset_tracker_unit_tb.sv -----
`default_nettype none

module channel_scan_offset_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csot_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int NUM_CH       = DEF_NUM_CHANNELS;
	localparam int FRAC         = DEF_FRAC_BITS;
	localparam int QUIET_LIMIT  = 1000;
	localparam int MAX_REPORTS  = 100;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int BURST_PACKETS = 64;
	localparam int THR_MAX      = 131071;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One input transaction as the tracker sees it.
	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic signed [ERR_W-1:0]  freq_err;
		logic signed [RSSI_W-1:0] rssi;
	} scan_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [CMD_W-1:0]     s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// Items waiting to be sent and channel reports waiting to come back.
	scan_item_t   scan_items[$];
	csot_result_t expected_reports[$];
	scan_item_t   held_item;

	int src_gap_max = 0;
	int sink_gap_max = 0;
	int src_wait = 0;
	int sink_wait = 0;
	int mismatch_count = 0;
	int report_count = 0;
	int quiet_cycles = 0;

	// Shadow of the tracker: per-channel records, scan position and registers.
	logic signed [ERR_W+FRAC-1:0] offset_q [NUM_CH];
	logic [RSSI_MAG_W-1:0]        rssi_mag [NUM_CH];
	logic [CNT_W-1:0]             pkt_cnt [NUM_CH];
	logic                         has_rec [NUM_CH];
	logic [CH_OUT_W-1:0]          cur_ch;
	logic [DWELL_W-1:0]           dwell_cnt;
	logic [DWELL_W-1:0]           dwell_lim;
	logic [WEIGHT_W-1:0]          weight;
	logic [THR_W-1:0]             warn_thr;
	logic [THR_W-1:0]             alarm_thr;

	channel_scan_offset_tracker_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one item to the shadow state and returns the channel report it causes.
	function automatic csot_result_t track_step(input scan_item_t item);
		csot_result_t rep;
		logic [CH_OUT_W-1:0] ch;
		logic [DWELL_W-1:0] lim;
		longint eq, acc, w, q, mag, rm;
		rep = '0;
		ch = cur_ch;
		case (item.cmd)
			CMD_TICK: begin
				lim = (dwell_lim == 0) ? DWELL_W'(1) : dwell_lim;
				if (dwell_cnt != CNT_MAX)
					dwell_cnt = dwell_cnt + 1'b1;
				if (dwell_cnt >= lim) begin
					dwell_cnt = '0;
					cur_ch = (ch + 1) % NUM_CH;
					rep.retune = 1'b1;
				end
			end
			CMD_PACKET: begin
				eq = longint'(item.freq_err) * (longint'(1) << FRAC);
				rm = -longint'(item.rssi);
				if (rm < 0)
					rm = 0;
				if (rm > 255)
					rm = 255;
				if (pkt_cnt[ch] != CNT_MAX)
					pkt_cnt[ch] = pkt_cnt[ch] + 1'b1;
				if (!has_rec[ch]) begin
					offset_q[ch] = eq;
				end else begin
					w = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
					acc = w * eq + (longint'(WEIGHT_ONE) - w) * longint'(offset_q[ch]);
					offset_q[ch] = acc >>> WEIGHT_SHIFT;
				end
				rssi_mag[ch] = rm;
				has_rec[ch] = 1'b1;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NUM_CH; i++) begin
					has_rec[i] = 1'b0;
					pkt_cnt[i] = '0;
				end
				cur_ch = '0;
				dwell_cnt = '0;
				rep.retune = 1'b1;
			end
			default: ;
		endcase

		// The record reported is the one of the channel before the step.
		rep.channel = cur_ch;
		rep.rec_channel = ch;
		rep.packet_count = pkt_cnt[ch];
		rep.has_data = has_rec[ch];
		rep.offset_class = CLASS_OK;
		if (has_rec[ch]) begin
			q = longint'(offset_q[ch]);
			mag = (q < 0) ? -q : q;
			rep.avg_offset_hz = q >>> FRAC;
			rep.last_rssi_dbm = -longint'(rssi_mag[ch]);
			if (mag > (longint'(alarm_thr) << FRAC))
				rep.offset_class = CLASS_ALARM;
			else if (mag > (longint'(warn_thr) << FRAC))
				rep.offset_class = CLASS_WARN;
		end
		return rep;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on report %0d: %s is %0d, expected %0d",
				report_count, what, got, want);
	endtask

	task automatic add_item(input logic [CMD_W-1:0] cmd, input int err, input int rssi);
		scan_item_t item;
		item.cmd = cmd;
		item.freq_err = err;
		item.rssi = rssi;
		scan_items.push_back(item);
	endtask

	// Writes one register while the block is idle and mirrors it in the shadow.
	task automatic write_reg(input csot_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DWELL_TICKS: dwell_lim = value[DWELL_W-1:0];
			REG_EMA_WEIGHT: weight = value[WEIGHT_W-1:0];
			REG_WARN_THR: warn_thr = value[THR_W-1:0];
			REG_ALARM_THR: alarm_thr = value[THR_W-1:0];
			default: ;
		endcase
	endtask

	// Waits until every queued item was sent and every report came back.
	task automatic drain();
		do
			@(negedge clk);
		while (scan_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
	endtask

	// Source side: presents queued items and predicts each accepted transaction.
	always @(posedge clk or negedge arst_n) begin : source
		scan_item_t next_item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_reports.push_back(track_step(held_item));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_wait > 0) begin
					s_axis_tvalid <= 1'b0;
					src_wait <= src_wait - 1;
				end else if (scan_items.size() != 0) begin
					next_item = scan_items.pop_front();
					held_item = next_item;
					s_axis_tdata <= {5'b0, next_item.rssi, next_item.freq_err};
					s_axis_tuser <= next_item.cmd;
					s_axis_tvalid <= 1'b1;
					src_wait <= $urandom_range(0, src_gap_max);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: stalls at random and checks each report against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : sink
		csot_result_t got, want;
		int hold;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_wait <= 0;
		end else begin
			hold = sink_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				report_count++;
				got = csot_result_t'(m_axis_tdata[RES_W-1:0]);
				if (expected_reports.size() == 0) begin
					report_mismatch("report with nothing expected", got.rec_channel, 0);
				end else begin
					want = expected_reports.pop_front();
					if (got.channel !== want.channel)
						report_mismatch("channel", got.channel, want.channel);
					if (got.retune !== want.retune)
						report_mismatch("retune", got.retune, want.retune);
					if (got.rec_channel !== want.rec_channel)
						report_mismatch("rec_channel", got.rec_channel, want.rec_channel);
					if (got.avg_offset_hz !== want.avg_offset_hz)
						report_mismatch("avg_offset_hz", got.avg_offset_hz, want.avg_offset_hz);
					if (got.last_rssi_dbm !== want.last_rssi_dbm)
						report_mismatch("last_rssi_dbm", got.last_rssi_dbm, want.last_rssi_dbm);
					if (got.packet_count !== want.packet_count)
						report_mismatch("packet_count", got.packet_count, want.packet_count);
					if (got.has_data !== want.has_data)
						report_mismatch("has_data", got.has_data, want.has_data);
					if (got.offset_class !== want.offset_class)
						report_mismatch("offset_class", got.offset_class, want.offset_class);
				end
				hold = $urandom_range(0, sink_gap_max);
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				sink_wait <= hold - 1;
			end else begin
				m_axis_tready <= 1'b1;
				sink_wait <= 0;
			end
		end
	end

	// Cycles since the last transaction on either stream.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int gap_opts[3] = '{0, 3, 11};
		int sel, err, rssi, base;
		logic [CMD_W-1:0] cmd;
		logic [CFG_W-1:0] value;

		// Shadow reset state.
		for (int i = 0; i < NUM_CH; i++) begin
			offset_q[i] = '0;
			rssi_mag[i] = '0;
			pkt_cnt[i] = '0;
			has_rec[i] = 1'b0;
		end
		cur_ch = '0;
		dwell_cnt = '0;
		dwell_lim = DWELL_RESET;
		weight = WEIGHT_RESET;
		warn_thr = WARN_RESET;
		alarm_thr = ALARM_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: empty record, first load, blending, RSSI clamps, unused command.
		add_item(CMD_TICK, 0, 0);
		add_item(CMD_PACKET, -131072, -200);
		add_item(CMD_PACKET, 131071, 0);
		add_item(CMD_PACKET, 0, -256);
		add_item(CMD_PACKET, -1, 255);
		add_item(CMD_UNUSED, 5, -5);
		add_item(CMD_PACKET, 6000, -50);
		add_item(CMD_CLEAR, 0, 0);
		add_item(CMD_PACKET, 5001, -80);
		drain();

		// Zero dwell limit hops on every tick; oversized weight replaces the average.
		write_reg(REG_DWELL_TICKS, 0);
		write_reg(REG_EMA_WEIGHT, 511);
		write_reg(REG_WARN_THR, 0);
		write_reg(REG_ALARM_THR, THR_MAX);
		repeat (9) add_item(CMD_TICK, 0, 0);
		add_item(CMD_PACKET, -3, -17);
		add_item(CMD_PACKET, 7, -1);
		add_item(CMD_CLEAR, -1, -1);
		drain();

		// Count three ticks, then lower the limit below the count.
		write_reg(REG_DWELL_TICKS, 4);
		write_reg(REG_EMA_WEIGHT, 0);
		write_reg(REG_WARN_THR, THR_MAX);
		write_reg(REG_ALARM_THR, 0);
		repeat (3) add_item(CMD_TICK, 0, 0);
		drain();
		write_reg(REG_DWELL_TICKS, 2);
		add_item(CMD_TICK, 0, 0);
		add_item(CMD_PACKET, 100, -60);
		add_item(CMD_PACKET, -100, -61);
		drain();

		// A burst of packets on one channel, back to back.
		write_reg(REG_EMA_WEIGHT, 128);
		add_item(CMD_CLEAR, 0, 0);
		for (int i = 0; i < BURST_PACKETS; i++)
			add_item(CMD_PACKET, int'($urandom), -int'($urandom_range(0, 200)));
		drain();

		// Random phases: new settings each time, mostly ticks and packets.
		for (int p = 0; p < RAND_PHASES; p++) begin
			src_gap_max = gap_opts[p % 3];
			sink_gap_max = gap_opts[(p / 3 + p) % 3];

			case ($urandom_range(0, 4))
				0: value = 0;
				1: value = 1;
				2: value = DWELL_MAX;
				default: value = $urandom_range(2, 12);
			endcase
			write_reg(REG_DWELL_TICKS, value);
			case ($urandom_range(0, 3))
				0: value = 0;
				1: value = WEIGHT_ONE;
				2: value = 511;
				default: value = $urandom_range(0, 511);
			endcase
			write_reg(REG_EMA_WEIGHT, value);
			case ($urandom_range(0, 3))
				0: value = 0;
				1: value = THR_MAX;
				default: value = $urandom_range(0, 40000);
			endcase
			write_reg(REG_WARN_THR, value);
			case ($urandom_range(0, 3))
				0: value = 0;
				1: value = THR_MAX;
				default: value = $urandom_range(0, 40000);
			endcase
			write_reg(REG_ALARM_THR, value);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 45)
					cmd = CMD_TICK;
				else if (sel < 93)
					cmd = CMD_PACKET;
				else if (sel < 96)
					cmd = CMD_CLEAR;
				else
					cmd = CMD_UNUSED;

				// Errors: full range, moderate, or close to a threshold of either sign.
				case ($urandom_range(0, 3))
					0: err = int'($urandom);
					1: err = int'($urandom_range(0, 40000)) - 20000;
					default: begin
						base = $urandom_range(0, 1) ? int'(warn_thr) : int'(alarm_thr);
						err = base + int'($urandom_range(0, 64)) - 32;
						if ($urandom_range(0, 1))
							err = -err;
						if (err > THR_MAX)
							err = THR_MAX;
						if (err < -THR_MAX - 1)
							err = -THR_MAX - 1;
					end
				endcase
				if ($urandom_range(0, 3) == 0)
					rssi = int'($urandom);
				else
					rssi = -int'($urandom_range(0, 200));
				add_item(cmd, err, rssi);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		while (expected_reports.size() != 0) begin
			void'(expected_reports.pop_front());
			report_mismatch("report never arrived", 0, 0);
		end

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
